>>> hdl/rhrp_pkg.sv
// shared types and constants of the hold ramp pedal
package rhrp_pkg;

	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned TimeW    = 16;
	localparam int unsigned PosW     = 8;
	localparam int unsigned ElapsedW = 8;

	// quotient bits produced by the divider, one per step
	localparam int unsigned DivSteps = PosW;
	localparam int unsigned DivCntW  = $clog2(DivSteps);

	localparam logic [TimeW-1:0] HoldTimeoutRst  = TimeW'(500);
	localparam logic [TimeW-1:0] RampUpTimeRst   = TimeW'(1000);
	localparam logic [TimeW-1:0] RampDownTimeRst = TimeW'(1000);
	localparam logic [PosW-1:0]  MaxPositionRst  = PosW'(255);

	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_PUSH    = 2'd1,
		REQ_RELEASE = 2'd2,
		REQ_PULL    = 2'd3
	} req_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_HOLD_TIMEOUT   = 2'd0,
		CFG_RAMP_UP_TIME   = 2'd1,
		CFG_RAMP_DOWN_TIME = 2'd2,
		CFG_MAX_POSITION   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic start;
		logic div_step;
		logic finish;
	} rhrp_cmd_t;

	typedef struct packed {
		logic tick;
		logic div_last;
	} rhrp_sts_t;

endpackage

>>> hdl/rhrp_ctrl.sv
// sequencer: accepts a word, runs the divider for ticks, hands the result on
module rhrp_ctrl import rhrp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  rhrp_sts_t sts,
	output rhrp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_ready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = sts.tick ? S_DIV : S_FIN;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				// wait for the output register to be free
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> hdl/rhrp_datapath.sv
// config registers, hold counter, restoring divider and position update
module rhrp_datapath import rhrp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic [1:0]          req_type,
	input  logic [ElapsedW-1:0] elapsed,
	input  rhrp_cmd_t           cmd,
	output rhrp_sts_t           sts,
	output logic                pressed,
	output logic [PosW-1:0]     pedal_position
);

	logic [TimeW-1:0]   hold_timeout_q, ramp_up_time_q, ramp_down_time_q;
	logic [PosW-1:0]    max_position_q;
	logic [TimeW-1:0]   hold_q;
	logic               held_q;
	logic [PosW-1:0]    pos_q;
	logic               tick_q;
	logic               sat_q;
	logic [TimeW-1:0]   rem_q;
	logic [TimeW-1:0]   div_q;
	logic [PosW-1:0]    quo_q;
	logic [DivCntW-1:0] cnt_q;
	logic               pressed_q;
	logic [PosW-1:0]    pos_out_q;

	logic [TimeW-1:0]   elapsed_ext;
	logic [TimeW-1:0]   hold_dec;
	logic               held_tick;
	logic [TimeW-1:0]   ramp_sel;
	logic [TimeW-1:0]   ramp_eff;
	logic [TimeW:0]     rem_shl;
	logic [TimeW:0]     rem_sub;
	logic               rem_ge;
	logic [PosW-1:0]    step;
	logic [PosW:0]      pos_sum;
	logic [PosW-1:0]    pos_tick;
	logic [PosW-1:0]    pos_next;

	assign elapsed_ext = TimeW'(elapsed);
	assign hold_dec    = (hold_q > elapsed_ext) ? hold_q - elapsed_ext : '0;
	assign held_tick   = (hold_dec != '0);
	assign ramp_sel    = held_tick ? ramp_up_time_q : ramp_down_time_q;
	// a zero ramp time counts as one
	assign ramp_eff    = (ramp_sel == '0) ? TimeW'(1) : ramp_sel;

	assign rem_shl = {rem_q, 1'b0};
	assign rem_sub = rem_shl - {1'b0, div_q};
	assign rem_ge  = !rem_sub[TimeW];

	// elapsed >= ramp means the quotient would pass the 8-bit range
	assign step    = sat_q ? {PosW{1'b1}} : quo_q;
	assign pos_sum = {1'b0, pos_q} + {1'b0, step};

	always_comb begin
		if (held_q) begin
			pos_tick = (pos_sum > {1'b0, max_position_q}) ? max_position_q : pos_sum[PosW-1:0];
		end else begin
			pos_tick = (pos_q > step) ? pos_q - step : '0;
		end
	end

	assign pos_next = tick_q ? pos_tick : pos_q;

	assign sts.tick     = (req_t'(req_type) == REQ_TICK);
	assign sts.div_last = (cnt_q == DivCntW'(DivSteps - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_timeout_q   <= HoldTimeoutRst;
			ramp_up_time_q   <= RampUpTimeRst;
			ramp_down_time_q <= RampDownTimeRst;
			max_position_q   <= MaxPositionRst;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_HOLD_TIMEOUT:   hold_timeout_q   <= cfg_data[TimeW-1:0];
				CFG_RAMP_UP_TIME:   ramp_up_time_q   <= cfg_data[TimeW-1:0];
				CFG_RAMP_DOWN_TIME: ramp_down_time_q <= cfg_data[TimeW-1:0];
				CFG_MAX_POSITION:   max_position_q   <= cfg_data[PosW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
			held_q <= 1'b0;
			pos_q  <= '0;
			tick_q <= 1'b0;
		end else if (cmd.start) begin
			tick_q <= sts.tick;
			unique case (req_t'(req_type))
				REQ_TICK: begin
					hold_q <= hold_dec;
					held_q <= held_tick;
				end
				REQ_PUSH: begin
					hold_q <= hold_timeout_q;
					held_q <= 1'b1;
				end
				REQ_RELEASE: begin
					held_q <= 1'b0;
				end
				REQ_PULL: begin
					hold_q <= '0;
					held_q <= 1'b0;
					pos_q  <= '0;
				end
				default: ;
			endcase
		end else if (cmd.finish) begin
			pos_q <= pos_next;
		end
	end

	// restoring division of elapsed*256 by the ramp time, one quotient bit a step
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= elapsed_ext;
			div_q <= ramp_eff;
			sat_q <= (elapsed_ext >= ramp_eff);
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sub[TimeW-1:0] : rem_shl[TimeW-1:0];
			quo_q <= {quo_q[PosW-2:0], rem_ge};
			cnt_q <= cnt_q + DivCntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			pressed_q <= held_q;
			pos_out_q <= pos_next;
		end
	end

	assign pressed        = pressed_q;
	assign pedal_position = pos_out_q;

endmodule

>>> hdl/retriggered_hold_ramp_pedal_core.sv
// sequence: a word is accepted in idle; a tick word then runs the 8-step restoring divider
// before the finishing state, other words go straight to it; finishing registers the result
// a new word is taken only once the last has finished; a waiting result stalls its finish only
// reset: asynchronous, clears hold counter, held flag and position to zero
// and returns the configuration registers to their default values
module retriggered_hold_ramp_pedal_core import rhrp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          req_type,
	input  logic [ElapsedW-1:0] elapsed,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                pressed,
	output logic [PosW-1:0]     pedal_position,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	rhrp_cmd_t cmd;
	rhrp_sts_t sts;

	rhrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rhrp_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.req_type       (req_type),
		.elapsed        (elapsed),
		.cmd            (cmd),
		.sts            (sts),
		.pressed        (pressed),
		.pedal_position (pedal_position)
	);

`ifndef NO_ASSERTIONS
	// one word in flight: no second word straight after an accepted one
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word accepted while one is in flight");

	// a new result is only produced from the finishing state
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result produced outside the finishing state");

	// after a result is produced the sequencer is back to idle
	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("sequencer not idle after producing a result");
`endif

endmodule
